// File: rtl/qpht_pkg.sv
// Shared types and constants for the quadratic probe hash table.
// Holds the request, result and queue entry structs and the status codes.
// Depends on nothing.
package qpht_pkg;

  localparam int unsigned KEY_W      = 64;
  localparam int unsigned KEY_LEN_W  = 5;
  localparam int unsigned PAYLOAD_W  = 64;
  localparam int unsigned SZ_W       = 11;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned COLL_W     = 32;
  localparam int unsigned HASH_W     = 64;
  localparam int unsigned MOD_BITS   = 8;
  localparam int unsigned MOD_STEPS  = HASH_W / MOD_BITS;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned DEF_TABLE_DEPTH   = 1024;
  localparam int unsigned DEF_MAX_KEY_CHARS = 16;
  localparam logic [SZ_W-1:0] TABLE_SIZE_RST = 11'd1024;

  localparam logic [HASH_W-1:0] HASH_MULT    = 64'd31;
  localparam logic [HASH_W-1:0] HASH_MULT_SQ = 64'd961;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_SEARCH = 1'b1
  } req_type_e;

  typedef struct packed {
    logic                 req_type;
    logic [KEY_W-1:0]     key_hi;
    logic [KEY_W-1:0]     key_lo;
    logic [KEY_LEN_W-1:0] key_len;
    logic [PAYLOAD_W-1:0] payload;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [SLOT_W-1:0]    slot;
    logic [PAYLOAD_W-1:0] payload_out;
    logic [COLL_W-1:0]    collision_count;
  } rsp_t;

  typedef struct packed {
    logic                 req_type;
    logic [KEY_W-1:0]     key_hi;
    logic [KEY_W-1:0]     key_lo;
    logic [KEY_LEN_W-1:0] key_len;
    logic [PAYLOAD_W-1:0] payload;
    logic [SZ_W-1:0]      home;
  } entry_t;

endpackage

// File: rtl/quadratic_probe_hash_table.sv
// Top level of the quadratic probe hash table: configuration register, front end,
// decoupling queue and probe engine. Depends on qpht_pkg and the qpht_* modules.
//
// Open-addressing hash table over keys of up to 16 characters. After reset the
// slot memory is swept clear, one entry a cycle, and no request is taken until
// the sweep is done. The front end takes one request at a time, hashes two key
// characters a cycle and reduces the hash eight bits a cycle. For each probe the
// probe engine reads a slot of the slot memory (B_READ) and checks the word read
// (B_CHECK); it takes a request from the queue in B_IDLE and hands off the
// result from B_DONE. A two-entry queue between them lets both work at once;
// the sustained rate is that of the slower side for the current mix of keys and
// probe walks. The table size must be written by the user only while the block
// is idle; the block itself does not enforce this.
module quadratic_probe_hash_table #(
  parameter int unsigned TABLE_DEPTH   = qpht_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned MAX_KEY_CHARS = qpht_pkg::DEF_MAX_KEY_CHARS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  qpht_pkg::req_t             in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output qpht_pkg::rsp_t             out_rsp_o,
  input  logic                       cfg_we_i,
  input  logic [qpht_pkg::SZ_W-1:0]  cfg_wdata_i
);
  import qpht_pkg::*;

  logic [SZ_W-1:0] table_size_q;
  logic [SZ_W-1:0] size;
  logic            clearing;
  logic            q_push, q_full, q_pop, q_valid;
  entry_t          q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RST;
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (table_size_q == '0) begin
      size = SZ_W'(1);
    end else if (32'(table_size_q) > 32'(TABLE_DEPTH)) begin
      size = SZ_W'(TABLE_DEPTH);
    end else begin
      size = table_size_q;
    end
  end

  qpht_front #(
    .MAX_KEY_CHARS(MAX_KEY_CHARS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size),
    .block_i    (clearing),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_push_o   (q_push),
    .q_full_i   (q_full),
    .q_entry_o  (q_in)
  );

  qpht_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  qpht_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_i      (size),
    .clearing_o  (clearing),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_entry_i   (q_out),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// File: rtl/qpht_front.sv
// Front end: accepts requests, trims the key, hashes it and reduces it to a home slot.
// Depends on qpht_pkg.
module qpht_front #(
  parameter int unsigned MAX_KEY_CHARS = qpht_pkg::DEF_MAX_KEY_CHARS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [qpht_pkg::SZ_W-1:0]     size_i,
  input  logic                          block_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  qpht_pkg::req_t                in_req_i,
  output logic                          q_push_o,
  input  logic                          q_full_i,
  output qpht_pkg::entry_t              q_entry_o
);
  import qpht_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_HASH = 4'b0010,
    F_MOD  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_e;

  localparam int unsigned CNT_W = $clog2(MOD_STEPS);

  fstate_e               state_q, state_d;
  entry_t                ent_q, ent_d;
  logic [2*KEY_W-1:0]    sh_q, sh_d;
  logic [KEY_LEN_W-1:0]  rem_q, rem_d;
  logic [HASH_W-1:0]     h_q, h_d;
  logic [SZ_W-1:0]       r_q, r_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic [KEY_LEN_W-1:0]  len_c;
  logic [2*KEY_W-1:0]    key_c;
  logic [7:0]            c0, c1;
  logic [SZ_W:0]         r_t;

  assign in_stall_o = (state_q != F_IDLE) || block_i;
  assign q_push_o   = (state_q == F_PUSH) && !q_full_i;
  assign q_entry_o  = ent_q;
  assign c0 = sh_q[2*KEY_W-1 -: 8];
  assign c1 = sh_q[2*KEY_W-9 -: 8];

  always_comb begin
    len_c = (in_req_i.key_len > KEY_LEN_W'(MAX_KEY_CHARS)) ?
            KEY_LEN_W'(MAX_KEY_CHARS) : in_req_i.key_len;
    key_c = {in_req_i.key_hi, in_req_i.key_lo};
    for (int k = 0; k < 16; k++) begin
      if (k >= int'(len_c)) begin
        key_c[2*KEY_W-1-8*k -: 8] = 8'd0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    ent_d   = ent_q;
    sh_d    = sh_q;
    rem_d   = rem_q;
    h_d     = h_q;
    r_d     = r_q;
    cnt_d   = cnt_q;
    r_t     = '0;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          ent_d.req_type = in_req_i.req_type;
          ent_d.key_hi   = key_c[2*KEY_W-1:KEY_W];
          ent_d.key_lo   = key_c[KEY_W-1:0];
          ent_d.key_len  = len_c;
          ent_d.payload  = in_req_i.payload;
          ent_d.home     = '0;
          sh_d    = key_c;
          rem_d   = len_c;
          h_d     = '0;
          state_d = F_HASH;
        end
      end
      F_HASH: begin
        if (rem_q == '0) begin
          r_d     = '0;
          cnt_d   = '0;
          state_d = F_MOD;
        end else if (rem_q >= KEY_LEN_W'(2)) begin
          h_d   = h_q * HASH_MULT_SQ + HASH_W'(c0) * HASH_MULT + HASH_W'(c1);
          rem_d = rem_q - KEY_LEN_W'(2);
          sh_d  = {sh_q[2*KEY_W-17:0], 16'd0};
        end else begin
          h_d   = h_q * HASH_MULT + HASH_W'(c0);
          rem_d = '0;
        end
      end
      F_MOD: begin
        r_t = {1'b0, r_q};
        for (int b = 0; b < int'(MOD_BITS); b++) begin
          r_t = {r_t[SZ_W-1:0], h_q[HASH_W-1-b]};
          if (r_t >= {1'b0, size_i}) begin
            r_t = r_t - {1'b0, size_i};
          end
        end
        r_d   = r_t[SZ_W-1:0];
        h_d   = {h_q[HASH_W-MOD_BITS-1:0], MOD_BITS'(0)};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MOD_STEPS - 1)) begin
          ent_d.home = r_t[SZ_W-1:0];
          state_d    = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
    h_q   <= h_d;
    r_q   <= r_d;
    cnt_q <= cnt_d;
  end

endmodule

// File: rtl/qpht_queue.sv
// Short register queue that decouples the hashing front end from the probe engine.
// Depends on qpht_pkg.
module qpht_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  qpht_pkg::entry_t   entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output qpht_pkg::entry_t   entry_o
);
  import qpht_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t            buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= entry_i;
    end
  end

endmodule

// File: rtl/qpht_back.sv
// Probe engine: owns the slot memory, walks the quadratic probe sequence and
// drives the result register. Depends on qpht_pkg.
module qpht_back #(
  parameter int unsigned TABLE_DEPTH = qpht_pkg::DEF_TABLE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [qpht_pkg::SZ_W-1:0]   size_i,
  output logic                        clearing_o,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  qpht_pkg::entry_t            q_entry_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output qpht_pkg::rsp_t              out_rsp_o
);
  import qpht_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_READ  = 5'b00100,
    B_CHECK = 5'b01000,
    B_DONE  = 5'b10000
  } bstate_e;

  typedef struct packed {
    logic                 used;
    logic [KEY_W-1:0]     key_hi;
    logic [KEY_W-1:0]     key_lo;
    logic [KEY_LEN_W-1:0] key_len;
    logic [PAYLOAD_W-1:0] payload;
  } word_t;

  word_t             mem [TABLE_DEPTH];
  word_t             rdata_q;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  word_t             wdata;

  bstate_e           state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  entry_t            ent_q, ent_d;
  logic [SZ_W-1:0]   slot_q, slot_d;
  logic [SZ_W-1:0]   delta_q, delta_d;
  logic [SZ_W-1:0]   i_q, i_d;
  logic [COLL_W-1:0] coll_q, coll_d;
  rsp_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic [SZ_W:0]     slot_nx, delta_nx;
  logic [COLL_W:0]   coll_sum;
  logic              match;

  assign clearing_o  = (state_q == B_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign q_pop_o     = (state_q == B_IDLE) && q_valid_i;

  assign match = (rdata_q.key_len == ent_q.key_len) && (rdata_q.key_hi == ent_q.key_hi) &&
                 (rdata_q.key_lo == ent_q.key_lo);

  always_comb begin
    slot_nx = {1'b0, slot_q} + {1'b0, delta_q};
    if (slot_nx >= {1'b0, size_i}) begin
      slot_nx = slot_nx - {1'b0, size_i};
    end
    delta_nx = {1'b0, delta_q} + (SZ_W+1)'(2);
    if (delta_nx >= {1'b0, size_i}) begin
      delta_nx = delta_nx - {1'b0, size_i};
    end
    if (delta_nx >= {1'b0, size_i}) begin
      delta_nx = delta_nx - {1'b0, size_i};
    end
    coll_sum = {1'b0, coll_q} + (COLL_W+1)'(i_q);
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ent_d       = ent_q;
    slot_d      = slot_q;
    delta_d     = delta_q;
    i_d         = i_q;
    coll_d      = coll_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = IDX_W'(slot_q);
    wdata.used    = 1'b1;
    wdata.key_hi  = ent_q.key_hi;
    wdata.key_lo  = ent_q.key_lo;
    wdata.key_len = ent_q.key_len;
    wdata.payload = ent_q.payload;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      B_CLEAR: begin
        we         = 1'b1;
        waddr      = clr_q;
        wdata.used = 1'b0;
        clr_d      = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(TABLE_DEPTH - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid_i) begin
          ent_d   = q_entry_i;
          slot_d  = q_entry_i.home;
          delta_d = (size_i == SZ_W'(1)) ? '0 : SZ_W'(1);
          i_d     = '0;
          state_d = B_READ;
        end
      end
      B_READ: begin
        state_d = B_CHECK;
      end
      B_CHECK: begin
        res_d.slot            = '0;
        res_d.payload_out     = '0;
        res_d.collision_count = coll_q;
        state_d               = B_DONE;
        if (!rdata_q.used) begin
          if (ent_q.req_type == REQ_INSERT) begin
            we     = 1'b1;
            coll_d = coll_sum[COLL_W] ? '1 : coll_sum[COLL_W-1:0];
            res_d.status          = ST_INSERTED;
            res_d.slot            = SLOT_W'(slot_q);
            res_d.collision_count = coll_d;
          end else begin
            res_d.status = ST_NOT_FOUND;
          end
        end else if ((ent_q.req_type == REQ_SEARCH) && match) begin
          res_d.status      = ST_FOUND;
          res_d.slot        = SLOT_W'(slot_q);
          res_d.payload_out = rdata_q.payload;
        end else if (i_q + SZ_W'(1) == size_i) begin
          res_d.status = (ent_q.req_type == REQ_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end else begin
          i_d     = i_q + SZ_W'(1);
          slot_d  = slot_nx[SZ_W-1:0];
          delta_d = delta_nx[SZ_W-1:0];
          state_d = B_READ;
        end
      end
      B_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      coll_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      coll_q      <= coll_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    slot_q  <= slot_d;
    delta_q <= delta_d;
    i_q     <= i_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[IDX_W'(slot_q)];
  end

endmodule
